[rtl/ffba_pkg.sv]
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int ADDR_BITS_DEF    = 16;

	localparam logic [15:0] HEAP_LIMIT_RST = 16'hFFFF;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [2:0] ST_REUSED   = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_NOSPACE  = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_NULL     = 3'd5;
	localparam logic [2:0] ST_BAD      = 3'd6;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_size;
		logic [15:0] release_address;
	} req_t;

	typedef struct packed {
		logic [15:0] data_address;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] size;
		logic        free;
	} entry_t;

endpackage

[rtl/ffba_table.sv]
module ffba_table #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [IDX_W-1:0]       rd_idx,
	output ffba_pkg::entry_t       rd_data,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_idx,
	input  ffba_pkg::entry_t       wr_data
);
	import ffba_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

[rtl/ffba_ctrl.sv]
module ffba_ctrl #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 24,
	parameter int ADDR_BITS    = 16,
	parameter int IDX_W        = 6,
	parameter int CNT_W        = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 heap_limit_we,
	input  logic [15:0]          heap_limit,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ffba_pkg::req_t       req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ffba_pkg::rsp_t       res,
	output logic                 rd_en,
	output logic [IDX_W-1:0]     rd_idx,
	input  ffba_pkg::entry_t     rd_data,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_idx,
	output ffba_pkg::entry_t     wr_data
);
	import ffba_pkg::*;

	localparam int MASK_BITS = (ADDR_BITS < 17) ? ADDR_BITS : 17;
	localparam logic [16:0] ADDR_MASK = 17'((64'(1) << MASK_BITS) - 64'(1));
	localparam logic [16:0] HDR = 17'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MISS = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [15:0]      limit_q;
	logic [CNT_W-1:0] count_q;
	logic [16:0]      heap_top_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic [CNT_W-1:0] iss_q;
	logic             op_q;
	logic [15:0]      size_q;
	logic [15:0]      addr_q;
	rsp_t             res_q;

	logic [16:0] rd_daddr;
	logic        rd_match;
	logic        hit;
	logic        last;
	logic [17:0] end_sum;
	logic [16:0] top_daddr;
	logic        fits;

	assign rd_daddr  = (17'(rd_data.start) + HDR) & ADDR_MASK;
	assign rd_match  = rd_daddr == 17'(addr_q);
	assign hit       = pend_s1 && ((op_q == OP_ALLOC) ?
		(rd_data.free && (rd_data.size >= size_q)) : rd_match);
	assign last      = (CNT_W'(pidx_s1) + CNT_W'(1)) == count_q;
	assign end_sum   = 18'(heap_top_q) + 18'(HDR) + 18'(size_q);
	assign top_daddr = (heap_top_q + HDR) & ADDR_MASK;
	assign fits      = (count_q < CNT_MAX) && (end_sum <= (18'(limit_q) + 18'd1));

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;
	assign rd_en     = (state_q == S_SCAN) && (iss_q < count_q);
	assign rd_idx    = iss_q[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = pidx_s1;
		wr_data = rd_data;
		case (state_q)
			S_SCAN: begin
				if (hit) begin
					if (op_q == OP_ALLOC) begin
						wr_en        = 1'b1;
						wr_data.free = 1'b0;
					end else if (!rd_data.free) begin
						wr_en        = 1'b1;
						wr_data.free = 1'b1;
					end
				end
			end
			S_MISS: begin
				if (op_q == OP_ALLOC && fits) begin
					wr_en   = 1'b1;
					wr_idx  = count_q[IDX_W-1:0];
					wr_data = '{start: heap_top_q[15:0], size: size_q, free: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= HEAP_LIMIT_RST;
			count_q    <= '0;
			heap_top_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			if (heap_limit_we) begin
				limit_q <= heap_limit;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (req_valid) begin
						if (req.opcode == OP_ALLOC && req.request_size == 16'd0) begin
							state_q <= S_DONE;
						end else if (req.opcode == OP_RELEASE &&
							req.release_address == 16'd0) begin
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= rd_en;
					if (hit) begin
						state_q <= S_DONE;
					end else if (pend_s1 && last) begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (op_q == OP_ALLOC && fits) begin
						count_q    <= count_q + CNT_W'(1);
						heap_top_q <= end_sum[16:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				iss_q  <= '0;
				op_q   <= req.opcode;
				size_q <= req.request_size;
				addr_q <= req.release_address;
				res_q  <= '{data_address: 16'd0,
					status: (req.opcode == OP_ALLOC) ? ST_ZERO : ST_NULL};
			end
			S_SCAN: begin
				if (rd_en) begin
					iss_q <= iss_q + CNT_W'(1);
				end
				pidx_s1 <= iss_q[IDX_W-1:0];
				if (hit) begin
					if (op_q == OP_ALLOC) begin
						res_q <= '{data_address: rd_daddr[15:0], status: ST_REUSED};
					end else begin
						res_q <= '{data_address: 16'd0,
							status: rd_data.free ? ST_BAD : ST_RELEASED};
					end
				end
			end
			S_MISS: begin
				if (op_q == OP_RELEASE) begin
					res_q <= '{data_address: 16'd0, status: ST_BAD};
				end else if (fits) begin
					res_q <= '{data_address: top_daddr[15:0], status: ST_NEW};
				end else begin
					res_q <= '{data_address: 16'd0, status: ST_NOSPACE};
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("block count past table depth");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q <= 17'h10000)
		else $error("heap top past heap end");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN || state_q == S_MISS))
		else $error("table write outside scan or append");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_MISS) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append without count advance");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> iss_q < count_q)
		else $error("read past last block");

endmodule

[rtl/first_fit_block_allocator.sv]
// A zero-size allocate or null release skips the scan: idle goes straight to the done state.
// Others scan the block table one entry per cycle through the memory read port, ending at a hit;
// a miss (append, no space, bad release) ends in the miss state, entered at once with no blocks.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset: control, block count and heap top clear asynchronously, heap_limit resets to 65535;
// the block table is not cleared and entries past the block count are never read.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
	parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           heap_limit_we,
	input  logic [15:0]    heap_limit,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffba_pkg::rsp_t rsp
);
	import ffba_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	logic             res_valid;
	logic             res_ready;
	rsp_t             res;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_data;
	logic             out_valid_q;
	rsp_t             rsp_q;

	ffba_ctrl #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.HEADER_BYTES(HEADER_BYTES),
		.ADDR_BITS   (ADDR_BITS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_limit_we(heap_limit_we),
		.heap_limit   (heap_limit),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.rd_en        (rd_en),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_data      (wr_data)
	);

	ffba_table #(
		.DEPTH(MAX_BLOCKS),
		.IDX_W(IDX_W)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_data(wr_data)
	);

	assign res_ready = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

[tb/first_fit_block_allocator_checker.sv]
module first_fit_block_allocator_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           heap_limit_we,
	input  logic [15:0]    heap_limit,
	input  logic           req_valid,
	input  logic           req_ready,
	input  ffba_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  ffba_pkg::rsp_t rsp,
	output int             mismatches,
	output int             pending
);
	import ffba_pkg::*;

	localparam int HDR  = HEADER_BYTES_DEF;
	localparam int NBLK = MAX_BLOCKS_DEF;

	logic [15:0] blk_start [NBLK];
	logic [15:0] blk_size [NBLK];
	logic        blk_free [NBLK];
	int          blk_count;
	logic [16:0] heap_top;
	logic [15:0] limit;
	rsp_t        due_replies [$];

	function automatic rsp_t allocate(input logic [15:0] req_bytes);
		rsp_t r;
		int   stop;
		bit   hit;
		r.data_address = '0;
		r.status = ST_ZERO;
		hit = 1'b0;
		if (req_bytes != 16'd0) begin
			for (int i = 0; i < blk_count; i++) begin
				if (!hit && blk_free[i] && blk_size[i] >= req_bytes) begin
					hit = 1'b1;
					blk_free[i] = 1'b0;
					r.data_address = blk_start[i] + 16'(HDR);
					r.status = ST_REUSED;
				end
			end
			if (!hit) begin
				stop = int'(heap_top) + HDR + int'(req_bytes);
				if (blk_count >= NBLK || stop > int'(limit) + 1) begin
					r.status = ST_NOSPACE;
				end else begin
					blk_start[blk_count] = heap_top[15:0];
					blk_size[blk_count] = req_bytes;
					blk_free[blk_count] = 1'b0;
					blk_count++;
					r.data_address = heap_top[15:0] + 16'(HDR);
					r.status = ST_NEW;
					heap_top = 17'(stop);
				end
			end
		end
		return r;
	endfunction

	function automatic rsp_t free_block(input logic [15:0] addr);
		rsp_t r;
		bit   hit;
		r.data_address = '0;
		r.status = ST_BAD;
		hit = 1'b0;
		if (addr == 16'd0) begin
			r.status = ST_NULL;
		end else begin
			for (int i = 0; i < blk_count; i++) begin
				if (!hit && 16'(blk_start[i] + 16'(HDR)) == addr) begin
					hit = 1'b1;
					if (!blk_free[i]) begin
						blk_free[i] = 1'b1;
						r.status = ST_RELEASED;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			blk_count = 0;
			heap_top = '0;
			limit = HEAP_LIMIT_RST;
			due_replies.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (heap_limit_we)
				limit = heap_limit;
			if (req_valid && req_ready) begin
				if (req.opcode == OP_ALLOC)
					want = allocate(req.request_size);
				else
					want = free_block(req.release_address);
				due_replies.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (due_replies.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, actual data_address %0d status %0d",
						$time, rsp.data_address, rsp.status);
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					if (rsp.data_address !== want.data_address) begin
						$display("%0t: data_address expected %0d, actual %0d",
							$time, want.data_address, rsp.data_address);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, rsp.status);
						mismatches++;
					end
				end
			end
			pending = due_replies.size();
		end
	end

endmodule

[tb/tb_first_fit_block_allocator.sv]
module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        heap_limit_we = 1'b0;
	logic [15:0] heap_limit = HEAP_LIMIT_RST;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	int          mismatches;
	int          pending;

	logic        quiet = 1'b0;
	int          stuck = 0;
	logic        grant_seen = 1'b0;
	logic [15:0] grant_addr = '0;
	logic [15:0] live [$];
	logic [15:0] last_freed = 16'd24;

	first_fit_block_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_limit_we(heap_limit_we),
		.heap_limit   (heap_limit),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp)
	);

	first_fit_block_allocator_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_limit_we(heap_limit_we),
		.heap_limit   (heap_limit),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= quiet || ($urandom_range(99) >= 22);
		grant_seen <= rsp_valid && rsp_ready && (rsp.status == ST_NEW || rsp.status == ST_REUSED);
		grant_addr <= rsp.data_address;
	end

	always @(negedge clk) begin
		if (grant_seen)
			live.push_back(grant_addr);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck == WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t form_request(input logic op, input logic [15:0] req_bytes,
		input logic [15:0] addr);
		req_t it;
		it.opcode = op;
		it.request_size = req_bytes;
		it.release_address = addr;
		return it;
	endfunction

	function automatic req_t make_item();
		req_t it;
		int   pick;
		int   idx;
		it.opcode = OP_RELEASE;
		it.request_size = 16'($urandom());
		it.release_address = 16'($urandom());
		pick = $urandom_range(99);
		if (pick < 48) begin
			it.opcode = OP_ALLOC;
			idx = $urandom_range(99);
			if (idx < 70)
				it.request_size = 16'($urandom_range(64, 1));
			else if (idx < 88)
				it.request_size = 16'($urandom_range(600, 65));
			else if (idx >= 97)
				it.request_size = 16'd0;
		end else if (pick < 85) begin
			if (live.size() > 0) begin
				idx = $urandom_range(live.size() - 1);
				it.release_address = live[idx];
				last_freed = live[idx];
				live.delete(idx);
			end
		end else if (pick < 90) begin
			it.release_address = last_freed;
		end else if (pick < 95) begin
			it.release_address = 16'd0;
		end
		return it;
	endfunction

	task automatic send(input req_t item);
		if (!quiet) begin
			while ($urandom_range(99) < 22) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] value);
		heap_limit <= value;
		heap_limit_we <= 1'b1;
		@(posedge clk);
		heap_limit_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] new_limit, input int n, input bit calm);
		drain();
		set_limit(new_limit);
		if (calm)
			quiet <= 1'b1;
		for (int k = 0; k < n; k++) begin
			if (calm && k == 150)
				quiet <= 1'b0;
			if (k == n / 2)
				drain();
			send(make_item());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send(form_request(OP_ALLOC, 16'd0, 16'hFFFF));
		send(form_request(OP_RELEASE, 16'hFFFF, 16'd0));
		send(form_request(OP_RELEASE, 16'd0, 16'hFFFF));
		send(form_request(OP_ALLOC, 16'd1, 16'd0));
		send(form_request(OP_ALLOC, 16'hFFFF, 16'd0));
		send(form_request(OP_ALLOC, 16'd100, 16'd0));
		send(form_request(OP_RELEASE, 16'd0, 16'd24));
		send(form_request(OP_RELEASE, 16'd0, 16'd24));
		send(form_request(OP_ALLOC, 16'd2, 16'd0));
		send(form_request(OP_ALLOC, 16'd1, 16'd0));
		send(form_request(OP_RELEASE, 16'd0, 16'd49));
		send(form_request(OP_ALLOC, 16'd100, 16'd0));
		send(form_request(OP_RELEASE, 16'd0, 16'd50));
		send(form_request(OP_ALLOC, 16'd200, 16'd0));

		// heap top is now 399: leave room for exactly one 10-byte block
		drain();
		set_limit(16'd432);
		send(form_request(OP_ALLOC, 16'd11, 16'd0));
		send(form_request(OP_ALLOC, 16'd10, 16'd0));
		send(form_request(OP_RELEASE, 16'd0, 16'd173));
		send(form_request(OP_ALLOC, 16'd1, 16'd0));

		run_phase(16'd0, 250, 1'b0);
		run_phase(16'd3000, 450, 1'b0);
		run_phase(16'hFFFF, 500, 1'b1);
		run_phase(16'd1200, 450, 1'b0);

		drain();
		repeat (80) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
